// ----- rtl/rhmf_pkg.sv -----
// ----------------------------------------------------------------------------
// RGB histogram median filter package
// Shared sizes, codes, control types and the border mirror function.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package rhmf_pkg;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_RADIUS = 7;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int LINE_ROWS  = 16;
  localparam int SLOT_W     = $clog2(LINE_ROWS);
  localparam int LS_AW      = SLOT_W + COL_W;
  localparam int CHANNELS   = 3;
  localparam int PIX_W      = 8 * CHANNELS;
  localparam int ROW_W      = 12;
  localparam int WID_W      = 11;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_RADIUS = 2'd2;

  typedef struct packed {
    logic inc;
    logic walk;
  } rhmf_hctl_t;

  typedef struct packed {
    logic inc_busy;
    logic walk_busy;
  } rhmf_hsts_t;

  // reflect-101 about 0 and last
  function automatic logic [ROW_W-1:0] mirror(input logic signed [13:0] x,
                                              input logic [ROW_W-1:0] last);
    logic signed [14:0] a;
    logic signed [14:0] l;
    l = $signed({3'b000, last});
    a = (x < 0) ? -15'(x) : 15'(x);
    if (a > l) a = 15'(2 * l - a);
    if (a < 0) a = '0;
    return a[ROW_W-1:0];
  endfunction
endpackage

// ----- rtl/rhmf_if.sv -----
// ----------------------------------------------------------------------------
// RGB histogram median filter channels
// Pixel input channel and median result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface rhmf_pix_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  modport source (output valid, opcode, red_in, green_in, blue_in, input ready);
  modport sink (input valid, opcode, red_in, green_in, blue_in, output ready);
endinterface

interface rhmf_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       frame_end;
  modport source (output valid, red_out, green_out, blue_out, frame_end, input ready);
  modport sink (input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface

// ----- rtl/rhmf_line_mem.sv -----
// ----------------------------------------------------------------------------
// RGB histogram median filter line store
// Row ring of pixels, one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module rhmf_line_mem (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [rhmf_pkg::LS_AW-1:0] wr_addr,
  input  logic [rhmf_pkg::PIX_W-1:0] wr_data,
  input  logic [rhmf_pkg::LS_AW-1:0] rd_addr,
  output logic [rhmf_pkg::PIX_W-1:0] rd_data
);
  import rhmf_pkg::*;

  logic [PIX_W-1:0] mem [0:(1<<LS_AW)-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

// ----- rtl/rhmf_hist.sv -----
// ----------------------------------------------------------------------------
// RGB histogram median filter histogram unit
// Per-channel 256-bin histograms: increment, then walk to the median bin
// while clearing every bin.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module rhmf_hist (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rhmf_pkg::rhmf_hctl_t       ctl,
  input  logic [rhmf_pkg::PIX_W-1:0] pix,
  input  logic [7:0]                 target,
  output rhmf_pkg::rhmf_hsts_t       sts,
  output logic [rhmf_pkg::PIX_W-1:0] med
);
  import rhmf_pkg::*;

  logic       inc_pend_r;
  logic       wk_act_r;
  logic [7:0] wk_k_r;
  logic       wv_r;
  logic [7:0] wa_r;
  logic [7:0] tgt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inc_pend_r <= 1'b0;
      wk_act_r   <= 1'b1;
      wv_r       <= 1'b0;
    end else begin
      inc_pend_r <= ctl.inc;
      wv_r       <= wk_act_r;
      if (ctl.walk) begin
        wk_act_r <= 1'b1;
      end else if (wk_act_r && wk_k_r == 8'hFF) begin
        wk_act_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    wa_r <= wk_k_r;
    if (!rst_n) begin
      wk_k_r <= '0;
    end else if (ctl.walk) begin
      wk_k_r <= '0;
      tgt_r  <= target;
    end else if (wk_act_r) begin
      wk_k_r <= wk_k_r + 8'd1;
    end
  end

  assign sts.inc_busy  = inc_pend_r;
  assign sts.walk_busy = wk_act_r | wv_r;

  for (genvar c = 0; c < CHANNELS; c++) begin : g_ch
    logic [7:0] mem [0:255];
    logic [7:0] q;
    logic [7:0] ra;
    logic [7:0] ra_r;
    logic [7:0] fwd;
    logic       we;
    logic [7:0] wa;
    logic [7:0] wd;
    logic       lw_en_r;
    logic [7:0] lw_a_r;
    logic [7:0] lw_d_r;
    logic [8:0] cum_r;
    logic       found_r;
    logic [7:0] med_r;
    logic [8:0] sum;

    assign ra  = wk_act_r ? wk_k_r : pix[8*c +: 8];
    assign fwd = (lw_en_r && lw_a_r == ra_r) ? lw_d_r : q;
    assign we  = wv_r | inc_pend_r;
    assign wa  = ra_r;
    assign wd  = wv_r ? 8'd0 : fwd + 8'd1;
    assign sum = cum_r + {1'b0, fwd};

    always_ff @(posedge clk) begin
      if (we) begin
        mem[wa] <= wd;
      end
      q      <= mem[ra];
      ra_r   <= ra;
      lw_a_r <= wa;
      lw_d_r <= wd;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        lw_en_r <= 1'b0;
      end else begin
        lw_en_r <= we;
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.walk) begin
        cum_r   <= '0;
        found_r <= 1'b0;
        med_r   <= 8'hFF;
      end else if (wv_r && !found_r) begin
        if (sum > {1'b0, tgt_r}) begin
          found_r <= 1'b1;
          med_r   <= wa_r;
        end else begin
          cum_r <= sum;
        end
      end
    end

    assign med[8*c +: 8] = med_r;
  end
endmodule

// ----- rtl/rgb_histogram_median_filter.sv -----
// ----------------------------------------------------------------------------
// RGB histogram median filter
// Streaming per-channel (2R+1)x(2R+1) median with reflect-101 borders.
// ----------------------------------------------------------------------------
// Pixels enter in raster order; each result leaves once its window is in the
// line store. After reset the histogram memories take a clearing pass during
// which no beat is taken. One beat is taken at a time. For a beat that yields
// a result, the window is read with one line-store read per window pixel,
// then a 256-bin walk of the histogram memories finds the median and clears
// every bin, and the result then waits until the output takes it.
`timescale 1ns / 1ps
module rgb_histogram_median_filter (
  input  logic        clk,
  input  logic        rst_n,
  rhmf_pix_if.sink    in_ch,
  rhmf_res_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rhmf_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_WIN   = 6'b000100,
    S_DRAIN = 6'b001000,
    S_WALK  = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t st_r, st_nxt;

  logic [WID_W-1:0] width_r;
  logic [ROW_W-1:0] height_r;
  logic [2:0]       radius_r;
  logic [ROW_W-1:0] in_row_r, out_row_r;
  logic [COL_W-1:0] in_col_r, out_col_r;
  logic signed [4:0] dy_r, dx_r;
  logic             rv_r;

  logic [WID_W-1:0] w_eff;
  logic [ROW_W-1:0] h_eff;
  logic [2:0]       r_eff;
  logic [ROW_W-1:0] last_row;
  logic [ROW_W-1:0] last_col;
  logic [12:0]      nr_sum, nc_sum;
  logic [ROW_W-1:0] need_row, need_col;
  logic signed [4:0] r_s;
  logic [3:0]       n_win;
  logic [7:0]       nn;
  logic             cfg_wr;
  logic             in_fire, out_fire;
  logic             is_last;
  logic             ls_we;
  logic [LS_AW-1:0] ls_wa, ls_ra;
  logic [PIX_W-1:0] ls_rd;
  logic [ROW_W-1:0] row_m, col_m;
  logic             win_done;
  logic             ready_ok;
  rhmf_hctl_t       hctl;
  rhmf_hsts_t       hsts;
  logic [PIX_W-1:0] med;

  assign w_eff = (width_r == '0) ? WID_W'(1) :
                 (width_r > WID_W'(MAX_WIDTH)) ? WID_W'(MAX_WIDTH) : width_r;
  assign h_eff = (height_r == '0) ? ROW_W'(1) : height_r;
  assign last_row = h_eff - ROW_W'(1);
  assign last_col = ROW_W'(w_eff) - ROW_W'(1);

  always_comb begin
    r_eff = radius_r;
    if (ROW_W'(r_eff) > last_col) r_eff = last_col[2:0];
    if (ROW_W'(r_eff) > last_row) r_eff = last_row[2:0];
  end

  assign r_s    = $signed({2'b00, r_eff});
  assign n_win  = {r_eff, 1'b1};
  assign nn     = n_win * n_win;
  assign nr_sum = {1'b0, out_row_r} + 13'(r_eff);
  assign nc_sum = 13'(out_col_r) + 13'(r_eff);
  assign need_row = (nr_sum > 13'(last_row)) ? last_row : nr_sum[ROW_W-1:0];
  assign need_col = (nc_sum > 13'(last_col)) ? last_col : nc_sum[ROW_W-1:0];
  assign ready_ok = (in_row_r > need_row) ||
                    (in_row_r == need_row && ROW_W'(in_col_r) > need_col);

  assign cfg_wr   = psel & penable & pwrite;
  assign pready   = 1'b1;
  assign in_ch.ready  = (st_r == S_IDLE) && !hsts.walk_busy;
  assign in_fire  = in_ch.valid & in_ch.ready;
  assign out_ch.valid = (st_r == S_OUT);
  assign out_fire = out_ch.valid & out_ch.ready;
  assign is_last  = (out_row_r == last_row) && (ROW_W'(out_col_r) == last_col);

  assign out_ch.red_out   = med[7:0];
  assign out_ch.green_out = med[15:8];
  assign out_ch.blue_out  = med[23:16];
  assign out_ch.frame_end = is_last;

  always_comb begin
    unique case (paddr[3:2])
      REG_WIDTH:  prdata = 32'(width_r);
      REG_HEIGHT: prdata = 32'(height_r);
      REG_RADIUS: prdata = 32'(radius_r);
      default:    prdata = '0;
    endcase
  end

  assign ls_we = in_fire && in_ch.opcode == OP_PIXEL && in_row_r < h_eff;
  assign ls_wa = {in_row_r[SLOT_W-1:0], in_col_r};
  assign row_m = mirror($signed({2'b00, out_row_r}) + 14'(dy_r), last_row);
  assign col_m = mirror($signed(14'(out_col_r)) + 14'(dx_r), last_col);
  assign ls_ra = {row_m[SLOT_W-1:0], col_m[COL_W-1:0]};
  assign win_done = (dx_r == r_s) && (dy_r == r_s);

  rhmf_line_mem u_line (
    .clk     (clk),
    .wr_en   (ls_we),
    .wr_addr (ls_wa),
    .wr_data ({in_ch.blue_in, in_ch.green_in, in_ch.red_in}),
    .rd_addr (ls_ra),
    .rd_data (ls_rd)
  );

  assign hctl.inc  = rv_r;
  assign hctl.walk = (st_r == S_DRAIN) && !rv_r && !hsts.inc_busy;

  rhmf_hist u_hist (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (hctl),
    .pix    (ls_rd),
    .target ({1'b0, nn[7:1]}),
    .sts    (hsts),
    .med    (med)
  );

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_ch.opcode == OP_PIXEL) st_nxt = (in_row_r < h_eff) ? S_CHECK : S_IDLE;
          else st_nxt = (in_row_r < h_eff) ? S_IDLE : S_CHECK;
        end
      end
      S_CHECK: begin
        if (out_row_r >= h_eff) st_nxt = S_IDLE;
        else if (in_row_r < h_eff && !ready_ok) st_nxt = S_IDLE;
        else st_nxt = S_WIN;
      end
      S_WIN:   if (win_done) st_nxt = S_DRAIN;
      S_DRAIN: if (hctl.walk) st_nxt = S_WALK;
      S_WALK:  if (!hsts.walk_busy) st_nxt = S_OUT;
      S_OUT:   if (out_fire) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      width_r   <= WID_W'(640);
      height_r  <= ROW_W'(480);
      radius_r  <= 3'd1;
      in_row_r  <= '0;
      in_col_r  <= '0;
      out_row_r <= '0;
      out_col_r <= '0;
      rv_r      <= 1'b0;
    end else begin
      st_r <= st_nxt;
      rv_r <= (st_r == S_WIN);
      if (cfg_wr && paddr[3:2] != 2'd3) begin
        unique case (paddr[3:2])
          REG_WIDTH:  width_r  <= pwdata[WID_W-1:0];
          REG_HEIGHT: height_r <= pwdata[ROW_W-1:0];
          REG_RADIUS: radius_r <= pwdata[2:0];
          default:    radius_r <= radius_r;
        endcase
        in_row_r  <= '0;
        in_col_r  <= '0;
        out_row_r <= '0;
        out_col_r <= '0;
      end else begin
        if (ls_we) begin
          if (WID_W'(in_col_r) == w_eff - WID_W'(1)) begin
            in_col_r <= '0;
            in_row_r <= in_row_r + ROW_W'(1);
          end else begin
            in_col_r <= in_col_r + COL_W'(1);
          end
        end
        if (out_fire) begin
          if (is_last) begin
            in_row_r  <= '0;
            in_col_r  <= '0;
            out_row_r <= '0;
            out_col_r <= '0;
          end else if (ROW_W'(out_col_r) == last_col) begin
            out_col_r <= '0;
            out_row_r <= out_row_r + ROW_W'(1);
          end else begin
            out_col_r <= out_col_r + COL_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_CHECK) begin
      dy_r <= -r_s;
      dx_r <= -r_s;
    end else if (st_r == S_WIN) begin
      if (dx_r == r_s) begin
        dx_r <= -r_s;
        dy_r <= dy_r + 5'sd1;
      end else begin
        dx_r <= dx_r + 5'sd1;
      end
    end
  end

`ifndef SYNTHESIS
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready)
    else $error("result shown while taking input");
  a_walk_clean: assert property (@(posedge clk) disable iff (!rst_n)
    hctl.walk |-> !hsts.walk_busy && !rv_r)
    else $error("walk started over pending work");
  a_out_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !hsts.walk_busy && !hsts.inc_busy)
    else $error("result shown before histogram settled");
`endif
endmodule
